>>> rtl/urx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urx_pkg
// Shared types and constants for the serial receive ring with RTS control.
// ----------------------------------------------------------------------------
package urx_pkg;

    // Default ring depth (holds one byte less than this)
    localparam int RING_DEPTH_DEF = 1024;

    // Field widths
    localparam int REQ_W    = 2;
    localparam int DATA_W   = 8;
    localparam int MARK_W   = 10;
    localparam int FILL_W   = 10;
    localparam int CFG_IDX_W = 1;

    // Register reset values
    localparam logic [MARK_W-1:0] LWM_RST = 10'd256;
    localparam logic [MARK_W-1:0] HWM_RST = 10'd896;

    // Byte left in the ring by a cancel
    localparam logic [DATA_W-1:0] CAN_BYTE = 8'h18;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LWM = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HWM = 1'b1;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_RX     = 2'd0,
        REQ_READ   = 2'd1,
        REQ_FLUSH  = 2'd2,
        REQ_CANCEL = 2'd3
    } t_req;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;   // run the accepted word against the ring
        logic load;   // move the result into the output register
    } t_cmd;

endpackage
`default_nettype wire

>>> rtl/uart_rx_ring_with_rts_flow_control_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_rx_ring_with_rts_flow_control_core
// Serial receive ring buffer with RTS watermark flow control.
// ----------------------------------------------------------------------------
// Each input word is one request: store a received byte, read one byte, flush,
// or cancel (flush and leave a single CAN byte). The ring holds up to
// RING_DEPTH-1 bytes; a byte arriving at a full ring is dropped and sets the
// sticky overflow flag. A receive raises RTS once the fill count reaches the
// high water mark, a successful read drops it below the low water mark. Every
// request returns one result word. The accepting edge updates the pointers and
// does the registered ring memory read. The load stage then loads the output
// register once it is free, and the result word becomes valid. The input is
// ready again after that load, so a new request is not accepted until the
// previous result has been loaded. The next request is accepted while an
// earlier result still waits at the output. It then holds in the load stage,
// with the input not ready, until the waiting word is taken. The ring memory
// needs no clearing after reset. The user must write the water marks through
// the config port only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module uart_rx_ring_with_rts_flow_control_core #(
    parameter int RING_DEPTH = urx_pkg::RING_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [urx_pkg::REQ_W-1:0]         i_req_type,
    input  wire logic [urx_pkg::DATA_W-1:0]        i_rx_byte,
    input  wire logic                              i_taken_as_realtime,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_read_valid,
    output logic [urx_pkg::DATA_W-1:0]             o_read_data,
    output logic                                   o_rts_asserted,
    output logic                                   o_overflow_seen,
    output logic [urx_pkg::FILL_W-1:0]             o_fill_count,
    input  wire logic                              i_cfg_we,
    input  wire logic [urx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [urx_pkg::MARK_W-1:0]        i_cfg_data
);

    urx_pkg::t_cmd w_cmd;

    // Sequence requests
    urx_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Ring and flags
    urx_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_req_type          (i_req_type),
        .i_rx_byte           (i_rx_byte),
        .i_taken_as_realtime (i_taken_as_realtime),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_read_valid        (o_read_valid),
        .o_read_data         (o_read_data),
        .o_rts_asserted      (o_rts_asserted),
        .o_overflow_seen     (o_overflow_seen),
        .o_fill_count        (o_fill_count)
    );

`ifndef SYNTH
    // One request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while another is in flight");

    // Load never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |-> (!o_out_valid || i_out_ready))
        else $error("result word overwritten");

    // Execute and load never coincide
    a_exec_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.exec && w_cmd.load))
        else $error("execute and load in the same cycle");

    // A failed read returns zero data
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_read_valid) |-> (o_read_data == '0))
        else $error("nonzero data on empty read");
`endif

endmodule
`default_nettype wire

>>> rtl/urx_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urx_ctrl
// Sequencer: accept a word, wait for the ring read, load the result.
// ----------------------------------------------------------------------------
module urx_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output urx_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    // Output register is free when empty or being taken now
    assign out_free = !r_out_valid || i_out_ready;

    // Issue commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.exec = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load = (r_state == S_LOAD) && out_free;
    end

    // Next state
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

>>> rtl/urx_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urx_dp
// Ring memory, pointers, fill count, RTS and overflow flags, output register.
// ----------------------------------------------------------------------------
module urx_dp #(
    parameter int RING_DEPTH = urx_pkg::RING_DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire urx_pkg::t_cmd                     i_cmd,
    input  wire logic [urx_pkg::REQ_W-1:0]         i_req_type,
    input  wire logic [urx_pkg::DATA_W-1:0]        i_rx_byte,
    input  wire logic                              i_taken_as_realtime,
    input  wire logic                              i_cfg_we,
    input  wire logic [urx_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [urx_pkg::MARK_W-1:0]        i_cfg_data,
    output logic                                   o_read_valid,
    output logic [urx_pkg::DATA_W-1:0]             o_read_data,
    output logic                                   o_rts_asserted,
    output logic                                   o_overflow_seen,
    output logic [urx_pkg::FILL_W-1:0]             o_fill_count
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = (PW > urx_pkg::MARK_W) ? PW : urx_pkg::MARK_W;

    // Ring storage
    logic [urx_pkg::DATA_W-1:0] r_mem [RING_DEPTH];
    logic [urx_pkg::DATA_W-1:0] r_mem_q;

    // Control state
    logic [PW-1:0]               r_wp, n_wp;
    logic [PW-1:0]               r_rp, n_rp;
    logic [PW-1:0]               r_fill, n_fill;
    logic                        r_rts, n_rts;
    logic                        r_ovf, n_ovf;
    logic                        r_hit, n_hit;
    logic [urx_pkg::MARK_W-1:0]  r_lwm;
    logic [urx_pkg::MARK_W-1:0]  r_hwm;

    // Output register
    logic                        r_out_rv;
    logic [urx_pkg::DATA_W-1:0]  r_out_data;
    logic                        r_out_rts;
    logic                        r_out_ovf;
    logic [urx_pkg::FILL_W-1:0]  r_out_fill;

    logic [PW-1:0]               wp_adv;
    logic [PW-1:0]               rp_adv;
    logic                        full;
    logic                        mem_we;
    logic                        mem_re;
    logic [urx_pkg::DATA_W-1:0]  mem_wdata;
    logic [CW-1:0]               fill_ext;

    // Wrap pointers at the ring depth
    assign wp_adv = (r_wp == PW'(RING_DEPTH - 1)) ? '0 : r_wp + PW'(1);
    assign rp_adv = (r_rp == PW'(RING_DEPTH - 1)) ? '0 : r_rp + PW'(1);
    assign full   = (r_fill == PW'(RING_DEPTH - 1));

    // Work out the effect of one request
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        n_rts     = r_rts;
        n_ovf     = r_ovf;
        n_hit     = r_hit;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_wdata = i_rx_byte;
        if (i_cmd.exec) begin
            n_hit = 1'b0;
            case (urx_pkg::t_req'(i_req_type))
                urx_pkg::REQ_RX: begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else if (!i_taken_as_realtime) begin
                        mem_we = 1'b1;
                        n_wp   = wp_adv;
                        n_fill = r_fill + PW'(1);
                    end
                    if (!r_rts && (CW'(n_fill) >= CW'(r_hwm))) begin
                        n_rts = 1'b1;
                    end
                end
                urx_pkg::REQ_READ: begin
                    if (r_fill != '0) begin
                        mem_re = 1'b1;
                        n_hit  = 1'b1;
                        n_rp   = rp_adv;
                        n_fill = r_fill - PW'(1);
                        if (r_rts && (CW'(n_fill) < CW'(r_lwm))) begin
                            n_rts = 1'b0;
                        end
                    end
                end
                urx_pkg::REQ_FLUSH: begin
                    n_rp   = r_wp;
                    n_fill = '0;
                    n_ovf  = 1'b0;
                    n_rts  = 1'b0;
                end
                urx_pkg::REQ_CANCEL: begin
                    mem_we    = 1'b1;
                    mem_wdata = urx_pkg::CAN_BYTE;
                    n_rp      = r_wp;
                    n_wp      = wp_adv;
                    n_fill    = PW'(1);
                    n_ovf     = 1'b0;
                    n_rts     = 1'b0;
                end
                default: begin
                    n_hit = 1'b0;
                end
            endcase
        end
    end

    // Write the ring
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= mem_wdata;
        end
    end

    // Read the ring
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mem_q <= r_mem[r_rp];
        end
    end

    // Hold pointers, flags and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
            r_rts  <= 1'b0;
            r_ovf  <= 1'b0;
            r_hit  <= 1'b0;
            r_lwm  <= urx_pkg::LWM_RST;
            r_hwm  <= urx_pkg::HWM_RST;
        end else begin
            r_wp   <= n_wp;
            r_rp   <= n_rp;
            r_fill <= n_fill;
            r_rts  <= n_rts;
            r_ovf  <= n_ovf;
            r_hit  <= n_hit;
            if (i_cfg_we) begin
                if (i_cfg_index == urx_pkg::CFG_LWM) begin
                    r_lwm <= i_cfg_data;
                end
                if (i_cfg_index == urx_pkg::CFG_HWM) begin
                    r_hwm <= i_cfg_data;
                end
            end
        end
    end

    assign fill_ext = CW'(r_fill);

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_rv   <= r_hit;
            r_out_data <= r_hit ? r_mem_q : '0;
            r_out_rts  <= r_rts;
            r_out_ovf  <= r_ovf;
            r_out_fill <= fill_ext[urx_pkg::FILL_W-1:0];
        end
    end

    assign o_read_valid    = r_out_rv;
    assign o_read_data     = r_out_data;
    assign o_rts_asserted  = r_out_rts;
    assign o_overflow_seen = r_out_ovf;
    assign o_fill_count    = r_out_fill;

endmodule
`default_nettype wire

>>> verif/urx_ring_scoreboard.sv
// ----------------------------------------------------------------------------
// urx_ring_scoreboard
// Watches the request, result and config ports of the receive ring, keeps
// its own copy of the ring, pointers, flags and water marks, and predicts one
// result word per accepted request. Results are compared field by field, in
// order, and failures are counted for the testbench top.
// ----------------------------------------------------------------------------
module urx_ring_scoreboard #(
    parameter int DEPTH = urx_pkg::RING_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [urx_pkg::REQ_W-1:0]     i_req_type,
    input  logic [urx_pkg::DATA_W-1:0]    i_rx_byte,
    input  logic                          i_taken_as_realtime,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic                          i_read_valid,
    input  logic [urx_pkg::DATA_W-1:0]    i_read_data,
    input  logic                          i_rts_asserted,
    input  logic                          i_overflow_seen,
    input  logic [urx_pkg::FILL_W-1:0]    i_fill_count,
    input  logic                          i_cfg_we,
    input  logic [urx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [urx_pkg::MARK_W-1:0]    i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                       read_valid;
        logic [urx_pkg::DATA_W-1:0] read_data;
        logic                       rts;
        logic                       ovf;
        logic [urx_pkg::FILL_W-1:0] fill;
    } t_ring_word;

    // Shadow copy of the ring and its control state
    logic [urx_pkg::DATA_W-1:0] ring_mem [DEPTH];
    int unsigned                wr_ptr;
    int unsigned                rd_ptr;
    logic                       rts_q;
    logic                       ovf_q;
    logic [urx_pkg::MARK_W-1:0] low_mark;
    logic [urx_pkg::MARK_W-1:0] high_mark;
    t_ring_word                 expected_words[$];
    int                         fails;

    initial begin
        fails = 0;
    end

    function automatic int unsigned bump(int unsigned p);
        return (p + 1 >= DEPTH) ? 0 : p + 1;
    endfunction

    function automatic int unsigned ring_fill();
        return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    endfunction

    // Apply one request to the shadow ring and return the word it produces
    function automatic t_ring_word predict_ring_step(urx_pkg::t_req req,
                                                     logic [urx_pkg::DATA_W-1:0] rx_val,
                                                     logic rt);
        t_ring_word  w;
        int unsigned nxt;
        w = '0;
        case (req)
            urx_pkg::REQ_RX: begin
                nxt = bump(wr_ptr);
                // a full ring drops the byte, realtime or not
                if (nxt == rd_ptr) begin
                    ovf_q = 1'b1;
                end else if (!rt) begin
                    ring_mem[wr_ptr] = rx_val;
                    wr_ptr = nxt;
                end
                if (!rts_q && ring_fill() >= high_mark) rts_q = 1'b1;
            end
            urx_pkg::REQ_READ: begin
                // an empty ring leaves RTS alone
                if (rd_ptr != wr_ptr) begin
                    w.read_valid = 1'b1;
                    w.read_data  = ring_mem[rd_ptr];
                    rd_ptr = bump(rd_ptr);
                    if (rts_q && ring_fill() < low_mark) rts_q = 1'b0;
                end
            end
            urx_pkg::REQ_FLUSH: begin
                rd_ptr = wr_ptr;
                ovf_q  = 1'b0;
                rts_q  = 1'b0;
            end
            default: begin
                // flush, then leave one CAN byte without re-checking RTS
                rd_ptr = wr_ptr;
                ovf_q  = 1'b0;
                rts_q  = 1'b0;
                ring_mem[wr_ptr] = urx_pkg::CAN_BYTE;
                wr_ptr = bump(wr_ptr);
            end
        endcase
        w.rts  = rts_q;
        w.ovf  = ovf_q;
        w.fill = urx_pkg::FILL_W'(ring_fill());
        return w;
    endfunction

    task automatic log_failure(string what, t_ring_word want, t_ring_word got);
        fails++;
        if (fails <= 10) begin
            $write("%0t %s: expected valid=%0d data=%02h rts=%0d ovf=%0d fill=%0d,",
                   $realtime, what, want.read_valid, want.read_data, want.rts, want.ovf,
                   want.fill);
            $display(" got valid=%0d data=%02h rts=%0d ovf=%0d fill=%0d",
                     got.read_valid, got.read_data, got.rts, got.ovf, got.fill);
        end
    endtask

    // Track config writes, predict on accepted requests, check accepted results
    always @(posedge i_clk) begin : monitor
        t_ring_word got;
        t_ring_word want;
        if (!i_rst_n) begin
            wr_ptr    = 0;
            rd_ptr    = 0;
            rts_q     = 1'b0;
            ovf_q     = 1'b0;
            low_mark  = urx_pkg::LWM_RST;
            high_mark = urx_pkg::HWM_RST;
            expected_words.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == urx_pkg::CFG_LWM) low_mark = i_cfg_data;
                else                                 high_mark = i_cfg_data;
            end
            if (i_in_valid && i_in_ready)
                expected_words.push_back(predict_ring_step(urx_pkg::t_req'(i_req_type),
                                                           i_rx_byte,
                                                           i_taken_as_realtime));
            if (i_out_valid && i_out_ready) begin
                got.read_valid = i_read_valid;
                got.read_data  = i_read_data;
                got.rts        = i_rts_asserted;
                got.ovf        = i_overflow_seen;
                got.fill       = i_fill_count;
                if (expected_words.size() == 0) begin
                    log_failure("result word with nothing expected", '0, got);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) log_failure("result word mismatch", want, got);
                end
            end
        end
        o_pending    <= expected_words.size();
        o_fail_count <= fails;
    end

endmodule

>>> verif/tb_uart_rx_ring_with_rts_flow_control_core.sv
// ----------------------------------------------------------------------------
// tb_uart_rx_ring_with_rts_flow_control_core
// Drives requests into the receive ring with random gaps and result stalls.
// A short directed run covers empty reads, realtime bytes, RTS hysteresis,
// flush and cancel; random bursts then fill and drain the ring under several
// water mark settings, extremes included. The scoreboard checks every word.
// ----------------------------------------------------------------------------
module tb_uart_rx_ring_with_rts_flow_control_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = urx_pkg::RING_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_WORDS    = 165;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic [urx_pkg::REQ_W-1:0]     i_req_type;
    logic [urx_pkg::DATA_W-1:0]    i_rx_byte;
    logic                          i_taken_as_realtime;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_read_valid;
    logic [urx_pkg::DATA_W-1:0]    o_read_data;
    logic                          o_rts_asserted;
    logic                          o_overflow_seen;
    logic [urx_pkg::FILL_W-1:0]    o_fill_count;
    logic                          i_cfg_we;
    logic [urx_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [urx_pkg::MARK_W-1:0]    i_cfg_data;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int n_rx = 0, n_read = 0, n_flush = 0, n_cancel = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int rx_left  = 0;
    int rx_stall = 0;

    always #1 i_clk = ~i_clk;

    uart_rx_ring_with_rts_flow_control_core #(.RING_DEPTH(DEPTH)) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_rx_byte          (i_rx_byte),
        .i_taken_as_realtime(i_taken_as_realtime),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_read_valid       (o_read_valid),
        .o_read_data        (o_read_data),
        .o_rts_asserted     (o_rts_asserted),
        .o_overflow_seen    (o_overflow_seen),
        .o_fill_count       (o_fill_count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    urx_ring_scoreboard #(.DEPTH(DEPTH)) u_scoreboard (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_ready         (o_in_ready),
        .i_req_type         (i_req_type),
        .i_rx_byte          (i_rx_byte),
        .i_taken_as_realtime(i_taken_as_realtime),
        .i_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .i_read_valid       (o_read_valid),
        .i_read_data        (o_read_data),
        .i_rts_asserted     (o_rts_asserted),
        .i_overflow_seen    (o_overflow_seen),
        .i_fill_count       (o_fill_count),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    // Result side: hold ready low for a drawn number of cycles after each word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall    = 0;
        end else if (o_out_valid && i_out_ready) begin
            if (rx_left == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
                rx_left  = $urandom_range(20, 60);
            end
            rx_left--;
            rx_stall = rx_quiet ? 0 : $urandom_range(0, 19);
            i_out_ready <= (rx_stall == 0);
        end else if (rx_stall > 0) begin
            rx_stall--;
            i_out_ready <= (rx_stall == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one request word after a drawn gap and hold it until accepted
    task automatic send_word(urx_pkg::t_req req, logic [urx_pkg::DATA_W-1:0] rx_val,
                             logic rt);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_req_type          <= req;
        i_rx_byte           <= rx_val;
        i_taken_as_realtime <= rt;
        case (req)
            urx_pkg::REQ_RX:    n_rx++;
            urx_pkg::REQ_READ:  n_read++;
            urx_pkg::REQ_FLUSH: n_flush++;
            default:            n_cancel++;
        endcase
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both water marks on consecutive cycles
    task automatic load_marks(logic [urx_pkg::MARK_W-1:0] lo, logic [urx_pkg::MARK_W-1:0] hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= urx_pkg::CFG_LWM;
        i_cfg_data  <= lo;
        @(posedge i_clk);
        i_cfg_index <= urx_pkg::CFG_HWM;
        i_cfg_data  <= hi;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        int            lwm_set [N_PHASES];
        int            hwm_set [N_PHASES];
        int            sent;
        int            burst_len;
        int            rx_pct;
        int            clear_pct;
        int            roll;
        urx_pkg::t_req req;

        lwm_set = '{0, 1023, 0, 1023, 12, 30, -1, -1};
        hwm_set = '{0, 1023, 1023, 0, 48, 40, -1, -1};

        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_req_type          = urx_pkg::REQ_RX;
        i_rx_byte           = '0;
        i_taken_as_realtime = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = urx_pkg::CFG_LWM;
        i_cfg_data          = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: tight marks so RTS rises at four bytes and drops below two
        load_marks(10'd2, 10'd4);
        send_word(urx_pkg::REQ_READ, 8'h00, 1'b0);       // read of an empty ring
        send_word(urx_pkg::REQ_RX, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_RX, 8'hFF, 1'b0);
        send_word(urx_pkg::REQ_RX, 8'hA5, 1'b1);         // realtime byte, not stored
        send_word(urx_pkg::REQ_RX, 8'h5A, 1'b0);
        send_word(urx_pkg::REQ_RX, 8'h3C, 1'b0);         // reaches high mark, RTS up
        send_word(urx_pkg::REQ_READ, 8'hFF, 1'b1);
        send_word(urx_pkg::REQ_READ, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_READ, 8'h00, 1'b0);       // below low mark, RTS down
        send_word(urx_pkg::REQ_RX, 8'h81, 1'b1);
        send_word(urx_pkg::REQ_CANCEL, 8'h00, 1'b0);     // leaves only CAN
        send_word(urx_pkg::REQ_READ, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_READ, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_RX, 8'h7E, 1'b0);
        send_word(urx_pkg::REQ_RX, 8'h01, 1'b0);
        send_word(urx_pkg::REQ_FLUSH, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_READ, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_CANCEL, 8'hFF, 1'b1);     // cancel from an empty ring
        send_word(urx_pkg::REQ_CANCEL, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_READ, 8'h00, 1'b0);
        send_word(urx_pkg::REQ_FLUSH, 8'hFF, 1'b1);
        drain_results();

        // Random: bursts leaning toward fill or drain under each mark setting
        for (int p = 0; p < N_PHASES; p++) begin
            load_marks((lwm_set[p] < 0) ? urx_pkg::MARK_W'($urandom_range(0, DEPTH + 6))
                                        : urx_pkg::MARK_W'(lwm_set[p]),
                       (hwm_set[p] < 0) ? urx_pkg::MARK_W'($urandom_range(0, DEPTH + 6))
                                        : urx_pkg::MARK_W'(hwm_set[p]));
            sent = 0;
            while (sent < PHASE_WORDS) begin
                burst_len = $urandom_range(40, 120);
                case ($urandom_range(0, 3))
                    0:       rx_pct = 95;
                    1:       rx_pct = 70;
                    2:       rx_pct = 45;
                    default: rx_pct = 20;
                endcase
                clear_pct = $urandom_range(0, 1) ? 0 : 2;
                tx_quiet  = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < burst_len && sent < PHASE_WORDS; k++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < clear_pct)                    req = urx_pkg::REQ_FLUSH;
                    else if (roll < 2 * clear_pct)           req = urx_pkg::REQ_CANCEL;
                    else if ($urandom_range(0, 99) < rx_pct) req = urx_pkg::REQ_RX;
                    else                                     req = urx_pkg::REQ_READ;
                    send_word(req, urx_pkg::DATA_W'($urandom_range(0, 255)),
                              ($urandom_range(0, 9) == 0));
                    sent++;
                end
            end
            drain_results();
        end

        repeat (8) @(posedge i_clk);
        $display("Ring depth %0d, %0d water mark settings:", DEPTH, N_PHASES + 1);
        $display("%0d receive, %0d read, %0d flush, %0d cancel words",
                 n_rx, n_read, n_flush, n_cancel);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
